// ----- hw/rtl/integer_matrix_determinant_defines.svh -----
// Assertion macros for the matrix determinant block.
// IMD_ASSERT checks an implication or a plain property on every rising clock edge.
// IMD_NEVER checks that a condition never holds.
`ifndef INTEGER_MATRIX_DETERMINANT_DEFINES_SVH
`define INTEGER_MATRIX_DETERMINANT_DEFINES_SVH

`ifndef SYNTHESIS
`define IMD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("imd assertion failed");
`define IMD_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("imd condition must never hold");
`else
`define IMD_ASSERT(label, clk, rst_n, prop)
`define IMD_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/imd_pkg.sv -----
package imd_pkg;

  // Width of the matrix size field and of the load counter.
  localparam int unsigned SizeW = 3;
  localparam int unsigned CntW  = 6;
  localparam int unsigned ElemW = 16;
  localparam int unsigned DetW  = 32;

  // Descriptor of a fully loaded matrix waiting for the back end.
  typedef struct packed {
    logic             bank;
    logic [SizeW-1:0] n;
  } job_t;

  // Status of the descriptor queue.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- hw/rtl/imd_queue.sv -----
module imd_queue
  import imd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          push_job_i,
  input  logic          pop_i,
  output job_t          head_o,
  output queue_status_t status_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.empty = (count_q == 2'd0);
  assign status_o.full  = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/imd_front.sv -----
module imd_front
  import imd_pkg::*;
#(
  parameter int unsigned MaxSize = 4,
  parameter int unsigned AddrW   = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [SizeW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ElemW-1:0] element_i,
  input  logic                    first_i,
  output logic                    push_o,
  output job_t                    push_job_o,
  input  logic                    release_i,
  input  logic [AddrW:0]          rd_addr_i,
  output logic signed [ElemW-1:0] rd_data_o
);

  localparam int unsigned Depth = MaxSize * MaxSize;

  // Two banks so a new matrix can load while the previous one is expanded.
  // Each bank spans the full power-of-two address range of one matrix.
  logic signed [ElemW-1:0] store_q [2**(AddrW+1)];

  logic [SizeW-1:0] size_q;
  logic [CntW-1:0]  load_cnt_q;
  logic             bank_q;
  logic [1:0]       busy_q;

  logic [SizeW-1:0] n_eff;
  logic [CntW-1:0]  total, cnt, cnt_nx;
  logic             accept, done;

  always_comb begin
    if (size_q == '0) begin
      n_eff = SizeW'(1);
    end else if (size_q > SizeW'(MaxSize)) begin
      n_eff = SizeW'(MaxSize);
    end else begin
      n_eff = size_q;
    end
  end

  assign total      = CntW'(n_eff) * CntW'(n_eff);
  assign in_ready_o = (busy_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt        = first_i ? '0 : load_cnt_q;
  assign cnt_nx     = cnt + CntW'(1);
  assign done       = (cnt_nx >= total);

  assign push_o          = accept && done;
  assign push_job_o.bank = bank_q;
  assign push_job_o.n    = n_eff;

  always_ff @(posedge clk_i) begin
    if (accept && (cnt < CntW'(Depth))) begin
      store_q[{bank_q, cnt[AddrW-1:0]}] <= element_i;
    end
    rd_data_o <= store_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SizeW'(4);
      load_cnt_q <= '0;
      bank_q     <= 1'b0;
      busy_q     <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      if (accept) begin
        load_cnt_q <= done ? '0 : cnt_nx;
        if (done) begin
          bank_q <= ~bank_q;
        end
      end
      if (push_o && !release_i) begin
        busy_q <= busy_q + 2'd1;
      end else if (release_i && !push_o) begin
        busy_q <= busy_q - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/imd_back.sv -----
module imd_back
  import imd_pkg::*;
#(
  parameter int unsigned MaxSize = 4,
  parameter int unsigned AddrW   = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  queue_status_t           q_status_i,
  input  job_t                    q_head_i,
  output logic                    pop_o,
  output logic [AddrW:0]          rd_addr_o,
  input  logic signed [ElemW-1:0] rd_data_i,
  output logic                    release_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DetW-1:0]         out_data_o
);

  localparam int unsigned ColW = $clog2(MaxSize);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_MUL, ST_ACC, ST_WRITE, ST_OUT
  } state_e;

  // Minor determinants indexed by the set of columns they use.
  logic [DetW-1:0] minor_q [2**MaxSize];

  state_e             state_q;
  logic               bank_q;
  logic [SizeW-1:0]   n_q;
  logic [MaxSize-1:0] mask_q;
  logic [ColW-1:0]    col_q;
  logic [SizeW-1:0]   pos_q;
  logic               neg_q;
  logic [DetW-1:0]    acc_q, prod_q, minor_rd_q;
  logic               minor_one_q;
  logic               out_valid_q;
  logic [DetW-1:0]    out_data_q;

  logic [MaxSize-1:0] col_bit, sub_mask, full_mask;
  logic [SizeW-1:0]   pop_cnt, row;
  logic [CntW-1:0]    elem_addr;
  logic               last_col;
  logic [DetW-1:0]    minor_val;

  always_comb begin
    pop_cnt = '0;
    for (int i = 0; i < MaxSize; i++) begin
      pop_cnt = pop_cnt + SizeW'(mask_q[i]);
    end
  end

  assign col_bit   = MaxSize'(1) << col_q;
  assign sub_mask  = mask_q & ~col_bit;
  assign full_mask = MaxSize'((1 << n_q) - 1);
  assign row       = n_q - pop_cnt;
  assign elem_addr = CntW'(row) * CntW'(n_q) + CntW'(col_q);
  assign rd_addr_o = {bank_q, elem_addr[AddrW-1:0]};
  assign last_col  = (SizeW'(col_q) == n_q - SizeW'(1));
  assign minor_val = minor_one_q ? DetW'(1) : minor_rd_q;

  assign pop_o       = (state_q == ST_IDLE) && !q_status_i.empty;
  assign release_o   = (state_q == ST_OUT) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      minor_q[mask_q] <= acc_q;
    end
    minor_rd_q  <= minor_q[sub_mask];
    minor_one_q <= (sub_mask == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      n_q         <= SizeW'(1);
      mask_q      <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_status_i.empty) begin
            bank_q  <= q_head_i.bank;
            n_q     <= q_head_i.n;
            mask_q  <= MaxSize'(1);
            col_q   <= '0;
            pos_q   <= '0;
            acc_q   <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if ((mask_q & col_bit) != '0) begin
            neg_q   <= pos_q[0];
            pos_q   <= pos_q + SizeW'(1);
            state_q <= ST_MUL;
          end else if (last_col) begin
            state_q <= ST_WRITE;
          end else begin
            col_q <= col_q + ColW'(1);
          end
        end
        ST_MUL: begin
          prod_q  <= DetW'(signed'(rd_data_i)) * minor_val;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= neg_q ? acc_q - prod_q : acc_q + prod_q;
          if (last_col) begin
            state_q <= ST_WRITE;
          end else begin
            col_q   <= col_q + ColW'(1);
            state_q <= ST_ISSUE;
          end
        end
        ST_WRITE: begin
          if (mask_q == full_mask) begin
            state_q <= ST_OUT;
          end else begin
            mask_q  <= mask_q + MaxSize'(1);
            col_q   <= '0;
            pos_q   <= '0;
            acc_q   <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_data_q  <= acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/integer_matrix_determinant.sv -----
// After the last element of an n x n matrix, its descriptor is queued until the back end takes it,
// expands every nonempty column subset and registers the determinant as the result.
// Throughput: the loader takes one element per cycle into one of two banks while a bank is free;
// the sustained rate is set by the single shared multiplier loop.
// Reset: asynchronous active low; clears control state and sets the size register to 4.
// Matrix and minor memories hold undefined contents until written.
`include "integer_matrix_determinant_defines.svh"

module integer_matrix_determinant
  import imd_pkg::*;
#(
  parameter int unsigned MAX_SIZE = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration: size_in_use.
  input  logic                    cfg_we_i,
  input  logic [SizeW-1:0]        cfg_data_i,
  // Element requests.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic signed [ElemW-1:0] s_axis_tdata,  // [15:0] element
  input  logic                    s_axis_tuser,  // [0] first
  // Determinant results.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [DetW-1:0]         m_axis_tdata   // [31:0] determinant
);

  // Address of one element inside a bank of the matrix store.
  localparam int unsigned AddrW = $clog2(MAX_SIZE * MAX_SIZE);

  logic                    push, pop, release_bank;
  job_t                    push_job, head_job;
  queue_status_t           q_status;
  logic [AddrW:0]          rd_addr;
  logic signed [ElemW-1:0] rd_data;

  // The front end stores each element into the bank being loaded. When a
  // matrix is complete it queues a descriptor and switches banks, so the
  // next matrix loads while the back end expands the previous one.
  imd_front #(
    .MaxSize (MAX_SIZE),
    .AddrW   (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .element_i  (s_axis_tdata),
    .first_i    (s_axis_tuser),
    .push_o     (push),
    .push_job_o (push_job),
    .release_i  (release_bank),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  // Two-entry queue of finished matrices between the two halves.
  imd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (q_status)
  );

  // The back end walks all column subsets in increasing order. Each subset's
  // minor is the signed sum of its row's elements times smaller minors, which
  // is the first-row cofactor expansion computed bottom-up with one multiplier.
  imd_back #(
    .MaxSize (MAX_SIZE),
    .AddrW   (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_head_i    (head_job),
    .pop_o       (pop),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .release_o   (release_bank),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // The loader must never complete a matrix while both banks are waiting.
  `IMD_NEVER(a_no_push_when_full, clk_i, rst_ni, push && q_status.full && !pop)
  // The back end only takes a descriptor that is really there.
  `IMD_NEVER(a_no_pop_when_empty, clk_i, rst_ni, pop && q_status.empty)
  // Freeing a bank coincides with loading the result register.
  `IMD_ASSERT(a_release_shows_result, clk_i, rst_ni, release_bank |=> m_axis_tvalid)

endmodule

// ----- test/imd_checker.sv -----
module imd_checker
  import imd_pkg::*;
#(
  parameter int unsigned MAX_SIZE = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [ElemW-1:0] s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [DetW-1:0]  m_axis_tdata,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = MAX_SIZE * MAX_SIZE;
  localparam int unsigned IdxW  = $clog2(Depth);

  logic [SizeW-1:0] size_reg;
  logic [ElemW-1:0] elem_mem [Depth];
  logic [CntW-1:0]  fill_cnt;
  logic [DetW-1:0]  det_q [$];
  int               err_cnt;
  int               res_cnt;

  function automatic int unsigned clamp_size(logic [SizeW-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return s;
  endfunction

  // Expansion along row 0, matrix packed row-major with stride n.
  function automatic int cofactor_det(int m[Depth], int unsigned n);
    int minor[Depth];
    int sum;
    int term;
    int k;
    sum = 0;
    if (n <= 1) return m[0];
    if (n == 2) return m[0] * m[3] - m[1] * m[2];
    for (int col = 0; col < n; col++) begin
      k = 0;
      for (int r = 1; r < n; r++)
        for (int c = 0; c < n; c++)
          if (c != col) begin
            minor[k] = m[r * n + c];
            k++;
          end
      term = m[col] * cofactor_det(minor, n - 1);
      if (col % 2) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  task automatic report_mismatch(input string what, input logic [DetW-1:0] got,
                                 input logic [DetW-1:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int unsigned n;
    int          work[Depth];
    logic [DetW-1:0] want;
    if (!rst_ni) begin
      size_reg = 4;
      fill_cnt = '0;
      det_q.delete();
    end else begin
      // A write at this edge only affects requests at later edges.
      if (s_axis_tvalid && s_axis_tready) begin
        n = clamp_size(size_reg);
        if (s_axis_tuser) fill_cnt = '0;
        if (fill_cnt < Depth) elem_mem[fill_cnt[IdxW-1:0]] = s_axis_tdata;
        fill_cnt = fill_cnt + 1'b1;
        if (fill_cnt >= n * n) begin
          for (int i = 0; i < Depth; i++) work[i] = 0;
          for (int i = 0; i < n * n; i++) work[i] = $signed(elem_mem[i]);
          det_q.push_back(cofactor_det(work, n));
          fill_cnt = '0;
        end
      end
      if (cfg_we_i) size_reg = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        res_cnt++;
        if (det_q.size() == 0) begin
          report_mismatch("unexpected determinant", m_axis_tdata, '0);
        end else begin
          want = det_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("determinant", m_axis_tdata, want);
        end
      end
    end
    pending_o = det_q.size();
  end

  initial begin
    err_cnt = 0;
    res_cnt = 0;
    pending_o = 0;
  end
  assign errors_o  = err_cnt;
  assign results_o = res_cnt;

endmodule

// ----- test/tb_integer_matrix_determinant.sv -----
module tb_integer_matrix_determinant;
  import imd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no request, result or register write before the run is
  // declared hung. The longest correct gap is a 4x4 expansion stretched
  // by receiver stalls, or the idle pause before a write.
  localparam int WatchdogLimit = 5000;
  // Settling time after the last result, covering the 4x4 latency.
  localparam int SettleCycles  = 300;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [SizeW-1:0] cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [ElemW-1:0] s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DetW-1:0]  m_axis_tdata;

  int errors;
  int pending;
  int results;
  int tx_idle_pct;
  int rx_idle_pct;
  int req_count;
  int stall_cnt;

  integer_matrix_determinant u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // The checker mirrors the block from the channels alone and reports the
  // number of failures, the results still owed and the results seen.
  imd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors_o     (errors),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random; the share is set per phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // The watchdog restarts on any accepted request, result or write.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WatchdogLimit) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("tb_integer_matrix_determinant NOT OK");
        $finish;
      end
    end
  end

  // Random element: the extremes and tiny values are favored so that many
  // determinants stay small, the rest covers all sixteen bits.
  function automatic logic [ElemW-1:0] pick_element();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return ElemW'($signed($urandom_range(6)) - 3);
      default: return ElemW'($urandom);
    endcase
  endfunction

  // Sends one element request, idling first at the sender's share. Valid
  // stays high between back-to-back requests.
  task automatic send_element(input logic [ElemW-1:0] elem, input logic first);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= elem;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    req_count++;
  endtask

  // Writes the size register once the block has nothing left to deliver.
  // A partial load causes no result, so the pause also lets any expansion
  // still in progress drain before the write.
  task automatic write_size(input logic [SizeW-1:0] size);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Well-formed matrices with random content, with some noise: a missing
  // first mark on element zero or a restart partway through.
  task automatic random_phase(input int unsigned n, input int budget);
    int sent;
    logic first;
    sent = 0;
    while (sent < budget) begin
      for (int k = 0; k < n * n; k++) begin
        if (k == 0) first = ($urandom_range(9) != 0);
        else first = ($urandom_range(39) == 0);
        send_element(pick_element(), first);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned sizes[10];
    int unsigned eff;
    sizes = '{1, 2, 3, 4, 0, 7, 5, 6, 2, 3};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    tx_idle_pct   = 25;
    rx_idle_pct   = 45;
    req_count     = 0;
    stall_cnt     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A full 4x4 at the reset size writes every entry of bank 0, so a later
    // size change never exposes an unwritten one. Extremes are mixed in.
    for (int k = 0; k < 16; k++) begin
      case (k % 4)
        0: send_element(16'h8000, k == 0);
        1: send_element(16'h7fff, 1'b0);
        2: send_element(ElemW'(k), 1'b0);
        default: send_element(16'hffff, 1'b0);
      endcase
    end
    // Half a matrix, then the size shrinks below the count already loaded:
    // the very next element completes the 2x2.
    for (int k = 0; k < 8; k++) send_element(pick_element(), k == 0);
    write_size(2);
    send_element(16'h7fff, 1'b0);

    // Three idling modes, each walking through all sizes including zero and
    // the ones that saturate. A partial load left over from noise carries
    // into the next size on purpose.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 25; rx_idle_pct = 45; end
        1: begin tx_idle_pct = 45; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      foreach (sizes[i]) begin
        write_size(sizes[i]);
        eff = (sizes[i] == 0) ? 1 : ((sizes[i] > 4) ? 4 : sizes[i]);
        random_phase(eff, 33);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d element requests and checked %0d determinants", req_count, results);
    $display("across sizes 0 to 7, restarts, missing first marks and three idling modes.");
    if (errors == 0) begin
      $display("tb_integer_matrix_determinant OK");
    end else begin
      $display("tb_integer_matrix_determinant NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/imd_pkg.sv
hw/rtl/imd_queue.sv
hw/rtl/imd_front.sv
hw/rtl/imd_back.sv
hw/rtl/integer_matrix_determinant.sv
test/imd_checker.sv
test/tb_integer_matrix_determinant.sv
